### src/mbwpf_pkg.sv
package mbwpf_pkg;

   localparam int ID_WIDTH      = 8;
   localparam int ADDR_WIDTH    = 8;
   localparam int COUNT_WIDTH   = 4;
   localparam int PAYLOAD_WIDTH = 64;
   localparam int BYTE_WIDTH    = 8;
   localparam int REQ_DATA_WIDTH = 88;

   localparam logic [BYTE_WIDTH-1:0] SYNC_BYTE         = 8'hFF;
   localparam logic [BYTE_WIDTH-1:0] WRITE_INSTRUCTION = 8'h00;
   localparam logic [BYTE_WIDTH-1:0] LENGTH_OVERHEAD   = 8'd3;

   localparam int QUEUE_DEPTH = 2;

   // One classified command as it sits in the queue.
   typedef struct packed {
      logic [PAYLOAD_WIDTH-1:0] payload;
      logic [ID_WIDTH-1:0]      node_id;
      logic [ADDR_WIDTH-1:0]    reg_address;
      logic [COUNT_WIDTH-1:0]   count;
      logic [BYTE_WIDTH-1:0]    len_byte;
      logic [BYTE_WIDTH-1:0]    sum_seed;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SYNC1,
      ST_SYNC2,
      ST_ID,
      ST_LEN,
      ST_INSTR,
      ST_ADDR,
      ST_DATA,
      ST_SUM
   } step_type;

endpackage

### src/motor_bus_write_packet_framer_unit.sv
// Channel | Dir | tdata fields, low bit up                          | tlast
// req_    | in  | node_id[7:0] reg_address[15:8] byte_count[19:16]    | -
//         |     | payload[83:20], zero pad [87:84]                    |
// rsp_    | out | tx_byte[7:0]                                        | frame_end
//
// A frame is 7 + count words (15 at the full count of eight bytes), sent one per
// cycle unless rsp_tready stalls; a filled queue keeps frames back to back.
// The front takes a command whenever the two-entry queue has room, also while
// the back is still sending or stalled on rsp_tready.
// Reset is synchronous: it empties the queue and the output register.
// A stall on rsp_tready holds the output word and freezes the sequencer.
module motor_bus_write_packet_framer_unit #(
   parameter int MAX_DATA_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   // node_id[7:0], reg_address[15:8], byte_count[19:16], payload[83:20], pad[87:84]
   input  logic [87:0] req_tdata,

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tx_byte[7:0]
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast
);

   localparam int IdLo    = 0;
   localparam int AddrLo  = IdLo + mbwpf_pkg::ID_WIDTH;
   localparam int CountLo = AddrLo + mbwpf_pkg::ADDR_WIDTH;
   localparam int PayLo   = CountLo + mbwpf_pkg::COUNT_WIDTH;

   mbwpf_pkg::cmd_type front_cmd;
   mbwpf_pkg::cmd_type queue_cmd;
   logic               queue_full;
   logic               queue_nonempty;
   logic               queue_pop;
   logic               push;

   // Accept a word whenever the queue has room.
   assign req_tready = !queue_full;
   assign push       = req_tvalid && req_tready;

   // Classify: clamp the count and seed the checksum.
   mbwpf_front #(
      .MAX_DATA_BYTES(MAX_DATA_BYTES)
   ) u_front (
      .node_id     (req_tdata[AddrLo-1:IdLo]),
      .reg_address (req_tdata[CountLo-1:AddrLo]),
      .byte_count  (req_tdata[PayLo-1:CountLo]),
      .payload     (req_tdata[PayLo+mbwpf_pkg::PAYLOAD_WIDTH-1:PayLo]),
      .cmd         (front_cmd)
   );

   // Decouple the front from the byte sequencer.
   mbwpf_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (front_cmd),
      .full     (queue_full),
      .pop      (queue_pop),
      .pop_cmd  (queue_cmd),
      .nonempty (queue_nonempty)
   );

   // Walk the frame one word at a time and fold data bytes into the checksum.
   mbwpf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_cmd      (queue_cmd),
      .q_nonempty (queue_nonempty),
      .q_pop      (queue_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_byte   (rsp_tdata),
      .out_last   (rsp_tlast)
   );

endmodule

### src/mbwpf_front.sv
module mbwpf_front #(
   parameter int MAX_DATA_BYTES = 8
) (
   input  logic [mbwpf_pkg::ID_WIDTH-1:0]      node_id,
   input  logic [mbwpf_pkg::ADDR_WIDTH-1:0]    reg_address,
   input  logic [mbwpf_pkg::COUNT_WIDTH-1:0]   byte_count,
   input  logic [mbwpf_pkg::PAYLOAD_WIDTH-1:0] payload,
   output mbwpf_pkg::cmd_type                  cmd
);

   localparam logic [mbwpf_pkg::COUNT_WIDTH-1:0] MaxCount =
      mbwpf_pkg::COUNT_WIDTH'(MAX_DATA_BYTES);

   logic [mbwpf_pkg::COUNT_WIDTH-1:0] count_sat;
   logic [mbwpf_pkg::BYTE_WIDTH-1:0]  len_byte;

   // Clamp the count, build the length byte and the header part of the checksum.
   always_comb begin
      count_sat = (byte_count > MaxCount) ? MaxCount : byte_count;
      len_byte  = mbwpf_pkg::BYTE_WIDTH'(count_sat) + mbwpf_pkg::LENGTH_OVERHEAD;
      cmd.payload     = payload;
      cmd.node_id     = node_id;
      cmd.reg_address = reg_address;
      cmd.count       = count_sat;
      cmd.len_byte    = len_byte;
      cmd.sum_seed    = mbwpf_pkg::SYNC_BYTE - node_id - len_byte - reg_address;
   end

endmodule

### src/mbwpf_cmd_queue.sv
module mbwpf_cmd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mbwpf_pkg::cmd_type push_cmd,
   output logic               full,
   input  logic               pop,
   output mbwpf_pkg::cmd_type pop_cmd,
   output logic               nonempty
);

   localparam int PtrWidth = $clog2(mbwpf_pkg::QUEUE_DEPTH);
   localparam int CntWidth = $clog2(mbwpf_pkg::QUEUE_DEPTH + 1);
   localparam logic [CntWidth-1:0] Depth = CntWidth'(mbwpf_pkg::QUEUE_DEPTH);

   mbwpf_pkg::cmd_type entry_ff [mbwpf_pkg::QUEUE_DEPTH];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] fill_ff, fill_in;

   function automatic logic [PtrWidth-1:0] next_ptr(input logic [PtrWidth-1:0] p);
      next_ptr = (p == PtrWidth'(mbwpf_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full     = (fill_ff == Depth);
   assign nonempty = (fill_ff != '0);
   assign pop_cmd  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff + CntWidth'(push) - CntWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### src/mbwpf_back.sv
module mbwpf_back (
   input  logic                               clock,
   input  logic                               reset,
   input  mbwpf_pkg::cmd_type                 q_cmd,
   input  logic                               q_nonempty,
   output logic                               q_pop,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic [mbwpf_pkg::BYTE_WIDTH-1:0]   out_byte,
   output logic                               out_last
);

   mbwpf_pkg::step_type state_ff, state_in;

   logic [mbwpf_pkg::PAYLOAD_WIDTH-1:0] data_ff, data_in;
   logic [mbwpf_pkg::ID_WIDTH-1:0]      id_ff, id_in;
   logic [mbwpf_pkg::ADDR_WIDTH-1:0]    addr_ff, addr_in;
   logic [mbwpf_pkg::BYTE_WIDTH-1:0]    len_ff, len_in;
   logic [mbwpf_pkg::COUNT_WIDTH-1:0]   left_ff, left_in;
   logic [mbwpf_pkg::BYTE_WIDTH-1:0]    sum_ff, sum_in;

   logic                                out_valid_ff, out_valid_in;
   logic [mbwpf_pkg::BYTE_WIDTH-1:0]    out_byte_ff, out_byte_in;
   logic                                out_last_ff, out_last_in;

   logic advance;
   logic load;

   assign advance   = !out_valid_ff || out_ready;
   assign out_valid = out_valid_ff;
   assign out_byte  = out_byte_ff;
   assign out_last  = out_last_ff;
   assign q_pop     = load;

   always_comb begin
      state_in     = state_ff;
      data_in      = data_ff;
      id_in        = id_ff;
      addr_in      = addr_ff;
      len_in       = len_ff;
      left_in      = left_ff;
      sum_in       = sum_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      load         = 1'b0;

      if (advance) begin
         out_valid_in = 1'b0;
         out_last_in  = 1'b0;
         unique case (state_ff)
            mbwpf_pkg::ST_IDLE: begin
               load = q_nonempty;
            end
            mbwpf_pkg::ST_SYNC1: begin
               out_valid_in = 1'b1;
               out_byte_in  = mbwpf_pkg::SYNC_BYTE;
               state_in     = mbwpf_pkg::ST_SYNC2;
            end
            mbwpf_pkg::ST_SYNC2: begin
               out_valid_in = 1'b1;
               out_byte_in  = mbwpf_pkg::SYNC_BYTE;
               state_in     = mbwpf_pkg::ST_ID;
            end
            mbwpf_pkg::ST_ID: begin
               out_valid_in = 1'b1;
               out_byte_in  = id_ff;
               state_in     = mbwpf_pkg::ST_LEN;
            end
            mbwpf_pkg::ST_LEN: begin
               out_valid_in = 1'b1;
               out_byte_in  = len_ff;
               state_in     = mbwpf_pkg::ST_INSTR;
            end
            mbwpf_pkg::ST_INSTR: begin
               out_valid_in = 1'b1;
               out_byte_in  = mbwpf_pkg::WRITE_INSTRUCTION;
               state_in     = mbwpf_pkg::ST_ADDR;
            end
            mbwpf_pkg::ST_ADDR: begin
               out_valid_in = 1'b1;
               out_byte_in  = addr_ff;
               state_in     = (left_ff == '0) ? mbwpf_pkg::ST_SUM : mbwpf_pkg::ST_DATA;
            end
            mbwpf_pkg::ST_DATA: begin
               out_valid_in = 1'b1;
               out_byte_in  = data_ff[mbwpf_pkg::BYTE_WIDTH-1:0];
               sum_in       = sum_ff - data_ff[mbwpf_pkg::BYTE_WIDTH-1:0];
               data_in      = data_ff >> mbwpf_pkg::BYTE_WIDTH;
               left_in      = left_ff - 1'b1;
               state_in     = (left_ff == mbwpf_pkg::COUNT_WIDTH'(1)) ?
                              mbwpf_pkg::ST_SUM : mbwpf_pkg::ST_DATA;
            end
            mbwpf_pkg::ST_SUM: begin
               out_valid_in = 1'b1;
               out_byte_in  = sum_ff;
               out_last_in  = 1'b1;
               load         = q_nonempty;
               state_in     = mbwpf_pkg::ST_IDLE;
            end
            default: begin
               state_in = mbwpf_pkg::ST_IDLE;
            end
         endcase

         // Take the next command straight from the queue.
         if (load) begin
            data_in  = q_cmd.payload;
            id_in    = q_cmd.node_id;
            addr_in  = q_cmd.reg_address;
            len_in   = q_cmd.len_byte;
            left_in  = q_cmd.count;
            sum_in   = q_cmd.sum_seed;
            state_in = mbwpf_pkg::ST_SYNC1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mbwpf_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
         out_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         out_last_ff  <= out_last_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff     <= data_in;
      id_ff       <= id_in;
      addr_ff     <= addr_in;
      len_ff      <= len_in;
      left_ff     <= left_in;
      sum_ff      <= sum_in;
      out_byte_ff <= out_byte_in;
   end

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_nonempty)
      else $error("command popped from an empty queue");

   a_data_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mbwpf_pkg::ST_DATA) |-> (left_ff != '0))
      else $error("data step entered with no bytes left");

   a_after_checksum: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mbwpf_pkg::ST_SUM && advance) |=>
      (out_last_ff && (state_ff == mbwpf_pkg::ST_SYNC1 || state_ff == mbwpf_pkg::ST_IDLE)))
      else $error("checksum word not flagged or sequencer did not restart");

   a_last_only_from_sum: assert property (@(posedge clock) disable iff (reset)
      $rose(out_last_ff) |-> $past(state_ff == mbwpf_pkg::ST_SUM))
      else $error("last flag raised outside the checksum step");

endmodule

### verif/motor_bus_write_packet_framer_unit_test.sv
module motor_bus_write_packet_framer_unit_test;

   localparam int MAX_DATA_BYTES   = 8;
   localparam int RANDOM_CMDS      = 200;
   // Cycles with no word moving on either side before the run is called dead.
   // The longest legal quiet stretch is the long receiver hold-off below.
   localparam int STALL_LIMIT      = 2000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int LONG_HOLD_AFTER  = 400;   // rsp words seen before the long hold
   localparam int DRAIN_CYCLES     = 40;

   // One register-write command. Packed with node_id lowest, so it drops
   // straight into the low 84 bits of req_tdata.
   typedef struct packed {
      logic [mbwpf_pkg::PAYLOAD_WIDTH-1:0] payload;
      logic [mbwpf_pkg::COUNT_WIDTH-1:0]   byte_count;
      logic [mbwpf_pkg::ADDR_WIDTH-1:0]    reg_address;
      logic [mbwpf_pkg::ID_WIDTH-1:0]      node_id;
   } write_cmd_type;

   // One frame byte as it should leave on rsp_.
   typedef struct packed {
      logic [mbwpf_pkg::BYTE_WIDTH-1:0] tx_byte;
      logic                             frame_end;
   } frame_word_type;

   logic                                 clock      = 1'b0;
   logic                                 reset      = 1'b1;
   logic                                 req_tvalid = 1'b0;
   logic                                 req_tready;
   logic [mbwpf_pkg::REQ_DATA_WIDTH-1:0] req_tdata  = '0;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   logic [mbwpf_pkg::BYTE_WIDTH-1:0]     rsp_tdata;
   logic                                 rsp_tlast;

   write_cmd_type  pending_cmds[$];     // commands not yet offered
   write_cmd_type  offered_cmd;         // command currently on req_tdata
   frame_word_type expected_bytes[$];   // frame bytes still to arrive

   int  send_gap       = 0;
   int  hold_left      = 0;
   int  words_seen     = 0;
   int  mismatches     = 0;
   int  idle_cycles    = 0;
   bit  long_hold_done = 1'b0;
   bit  no_idle        = 1'b0;       // set for the tail of the run

   motor_bus_write_packet_framer_unit #(
      .MAX_DATA_BYTES(MAX_DATA_BYTES)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
   endtask

   // Build the whole frame for one accepted command and append it to the
   // expected bytes. Counts above the maximum saturate; payload bytes past
   // the count never show up and never enter the checksum.
   function automatic void predict_frame(input write_cmd_type cmd);
      logic [mbwpf_pkg::COUNT_WIDTH-1:0] count;
      logic [mbwpf_pkg::BYTE_WIDTH-1:0]  len_byte;
      logic [mbwpf_pkg::BYTE_WIDTH-1:0]  sum;
      logic [mbwpf_pkg::BYTE_WIDTH-1:0]  data_byte;
      count = (cmd.byte_count > MAX_DATA_BYTES) ?
              mbwpf_pkg::COUNT_WIDTH'(MAX_DATA_BYTES) : cmd.byte_count;
      len_byte = mbwpf_pkg::BYTE_WIDTH'(count) + mbwpf_pkg::LENGTH_OVERHEAD;
      sum      = mbwpf_pkg::SYNC_BYTE - cmd.node_id - len_byte - cmd.reg_address;
      expected_bytes.push_back({mbwpf_pkg::SYNC_BYTE, 1'b0});
      expected_bytes.push_back({mbwpf_pkg::SYNC_BYTE, 1'b0});
      expected_bytes.push_back({cmd.node_id, 1'b0});
      expected_bytes.push_back({len_byte, 1'b0});
      expected_bytes.push_back({mbwpf_pkg::WRITE_INSTRUCTION, 1'b0});
      expected_bytes.push_back({cmd.reg_address, 1'b0});
      for (int i = 0; i < count; i++) begin
         data_byte = cmd.payload[8*i +: 8];
         sum       = sum - data_byte;
         expected_bytes.push_back({data_byte, 1'b0});
      end
      expected_bytes.push_back({sum, 1'b1});
   endfunction

   task automatic queue_cmd(input logic [7:0] id, input logic [7:0] addr,
                            input logic [3:0] count, input logic [63:0] data);
      write_cmd_type cmd;
      cmd.node_id     = id;
      cmd.reg_address = addr;
      cmd.byte_count  = count;
      cmd.payload     = data;
      pending_cmds.push_back(cmd);
   endtask

   // Hold until every queued command is taken and every frame byte is back.
   task automatic wait_for_drain();
      while (pending_cmds.size() > 0 || req_tvalid || expected_bytes.size() > 0)
         @(negedge clock);
   endtask

   // Driver: advance to the next pending command once the current word is
   // taken; between commands, drop tvalid at random for a random gap.
   // A word on offer stays put while req_tready is low.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_frame(offered_cmd);
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
               send_gap = $urandom_range(1, 10) - 1;
               req_tvalid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
               offered_cmd = pending_cmds.pop_front();
               req_tdata  <= {4'b0, offered_cmd};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each accepted word against the oldest expected byte,
   // then pick the next rsp_tready. Once, after enough words, hold off for a
   // long stretch so the command queue fills and req_tready drops.
   always @(posedge clock) begin
      frame_word_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            words_seen++;
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("unexpected word %h last %b",
                                         rsp_tdata, rsp_tlast));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_tdata !== want.tx_byte) begin
                  report_mismatch($sformatf("tx_byte %h, want %h",
                                            rsp_tdata, want.tx_byte));
               end
               if (rsp_tlast !== want.frame_end) begin
                  report_mismatch($sformatf("frame_end %b, want %b on byte %h",
                                            rsp_tlast, want.frame_end, want.tx_byte));
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!long_hold_done && words_seen >= LONG_HOLD_AFTER) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else if (!no_idle && $urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(1, 10) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run if no word moves on either side for too long.
   initial begin
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
   end

   initial begin
      logic [3:0] count;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: field extremes, every count, saturation, ignored bytes.
      queue_cmd(8'h00, 8'h00, 4'd0, 64'h0);
      queue_cmd(8'hFF, 8'hFF, 4'd8, '1);
      queue_cmd(8'hFF, 8'hFF, 4'd0, '1);                  // zero count, junk payload
      queue_cmd(8'h01, 8'h1E, 4'd1, 64'hDEAD_BEEF_0000_00AB); // upper bytes ignored
      queue_cmd(8'h55, 8'hAA, 4'd2, 64'hFFFF_FFFF_FFFF_1234);
      queue_cmd(8'hAA, 8'h55, 4'd3, {$urandom, $urandom});
      queue_cmd(8'h0F, 8'hF0, 4'd4, {$urandom, $urandom});
      queue_cmd(8'hF0, 8'h0F, 4'd5, {$urandom, $urandom});
      queue_cmd(8'h80, 8'h01, 4'd6, {$urandom, $urandom});
      queue_cmd(8'h7F, 8'hFE, 4'd7, {$urandom, $urandom});
      queue_cmd(8'h03, 8'h20, 4'd8, 64'h0807_0605_0403_0201);
      queue_cmd(8'h12, 8'h34, 4'd9, 64'h1122_3344_5566_7788);  // saturate to 8
      queue_cmd(8'hFE, 8'h80, 4'd12, '1);
      queue_cmd(8'h00, 8'hFF, 4'd15, 64'h0);
      queue_cmd(8'hFC, 8'h00, 4'd0, 64'h0);               // checksum of zero
      queue_cmd(8'h00, 8'h00, 4'd8, 64'h8000_0000_0000_0000);
      queue_cmd(8'h01, 8'h02, 4'd10, 64'h5555_5555_AAAA_AAAA);

      // Pause the sender until the directed frames are all back.
      wait_for_drain();

      for (int n = 0; n < RANDOM_CMDS; n++) begin
         count = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15))
                                             : 4'($urandom_range(0, 8));
         queue_cmd(8'($urandom), 8'($urandom), count, {$urandom, $urandom});
      end

      // Run the tail with no idling on either side.
      while (pending_cmds.size() > 30) @(negedge clock);
      no_idle = 1'b1;

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_bytes.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
